>>> rtl/fpsl_pkg.sv
// ----------------------------------------------------------------------------
// fpsl_pkg
// Shared codes, reset values and types for the passive serial loader.
// ----------------------------------------------------------------------------
package fpsl_pkg;

    // Input operation codes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_DATA  = 2'd2;
    localparam logic [1:0] OP_ABORT = 2'd3;

    // Sequencer phases
    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_SET_HI   = 4'd1;
    localparam logic [3:0] PH_SET_LO   = 4'd2;
    localparam logic [3:0] PH_W_NST_LO = 4'd3;
    localparam logic [3:0] PH_W_CD_LO  = 4'd4;
    localparam logic [3:0] PH_W_NST_HI = 4'd5;
    localparam logic [3:0] PH_LOAD     = 4'd6;
    localparam logic [3:0] PH_W_DONE   = 4'd7;
    localparam logic [3:0] PH_DONE     = 4'd8;
    localparam logic [3:0] PH_FAIL     = 4'd9;
    localparam logic [3:0] PH_ABORT    = 4'd10;

    // Error codes
    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_NST_HIGH    = 3'd1;
    localparam logic [2:0] ERR_CD_HIGH     = 3'd2;
    localparam logic [2:0] ERR_NST_LOW     = 3'd3;
    localparam logic [2:0] ERR_CD_NEVER    = 3'd4;
    localparam logic [2:0] ERR_BYTE_UNEXP  = 3'd5;

    // Register map (word index)
    localparam logic [1:0] REG_USE_CD    = 2'd0;
    localparam logic [1:0] REG_SETTLE    = 2'd1;
    localparam logic [1:0] REG_INIT_LIM  = 2'd2;
    localparam logic [1:0] REG_DONE_LIM  = 2'd3;

    // Register reset values
    localparam logic        USE_CD_RST   = 1'b1;
    localparam logic [15:0] SETTLE_RST   = 16'd10000;
    localparam logic [15:0] INIT_LIM_RST = 16'd200;
    localparam logic [15:0] DONE_LIM_RST = 16'hFFFF;

    localparam int BYTE_W = 8;

    typedef struct packed {
        logic        use_cd;
        logic [15:0] settle;
        logic [15:0] init_lim;
        logic [15:0] done_lim;
    } fpsl_cfg_t;

    // One processed item: pin/phase snapshot plus byte to serialize
    typedef struct packed {
        logic              nconfig;
        logic [3:0]        phase;
        logic [2:0]        error;
        logic              pulse;
        logic [BYTE_W-1:0] data;
    } fpsl_res_t;

endpackage

>>> rtl/fpsl_if.sv
// ----------------------------------------------------------------------------
// fpsl_in_if / fpsl_out_if
// Valid/ready channels carrying loader commands and loader results.
// ----------------------------------------------------------------------------
interface fpsl_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       nstatus_level;
    logic       conf_done_level;

    modport source (
        output valid, op, data_byte, last_byte, nstatus_level, conf_done_level,
        input  ready
    );
    modport sink (
        input  valid, op, data_byte, last_byte, nstatus_level, conf_done_level,
        output ready
    );
endinterface

interface fpsl_out_if;
    logic       valid;
    logic       ready;
    logic       nconfig_level;
    logic       data_level;
    logic       dclk_pulse;
    logic [3:0] phase;
    logic [2:0] error_code;
    logic       last_of_run;

    modport source (
        output valid, nconfig_level, data_level, dclk_pulse, phase, error_code,
               last_of_run,
        input  ready
    );
    modport sink (
        input  valid, nconfig_level, data_level, dclk_pulse, phase, error_code,
               last_of_run,
        output ready
    );
endinterface

>>> rtl/fpsl_seq.sv
// ----------------------------------------------------------------------------
// fpsl_seq
// Configuration sequencer: phase, wait counter, error and nCONFIG state.
// ----------------------------------------------------------------------------
module fpsl_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [1:0]          op,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    input  logic                nstatus_level,
    input  logic                conf_done_level,
    input  fpsl_pkg::fpsl_cfg_t cfg,
    output fpsl_pkg::fpsl_res_t res
);
    import fpsl_pkg::*;

    logic [3:0]  phase_reg, phase_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [2:0]  err_reg, err_next;
    logic        ncfg_reg, ncfg_next;

    logic [15:0] cnt_inc;
    logic [15:0] lim_sel;
    logic        reached;
    logic        pulse;

    // Limit that applies to the current phase
    always_comb
    begin
        unique case (phase_reg)
            PH_SET_HI, PH_SET_LO, PH_ABORT: lim_sel = cfg.settle;
            PH_W_DONE:                      lim_sel = cfg.done_lim;
            default:                        lim_sel = cfg.init_lim;
        endcase
    end

    assign cnt_inc = cnt_reg + 16'd1;
    // wrap to zero counts as reached
    assign reached = (cnt_inc >= lim_sel) || (cnt_inc == 16'd0);

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        err_next   = err_reg;
        ncfg_next  = ncfg_reg;
        pulse      = 1'b0;
        unique case (op)
            OP_START:
            begin
                ncfg_next  = 1'b1;
                err_next   = ERR_NONE;
                phase_next = PH_SET_HI;
                cnt_next   = 16'd0;
            end
            OP_TICK:
            begin
                unique case (phase_reg)
                    PH_SET_HI:
                    begin
                        if (reached)
                        begin
                            ncfg_next  = 1'b0;
                            phase_next = PH_SET_LO;
                            cnt_next   = 16'd0;
                        end
                        else
                            cnt_next = cnt_inc;
                    end
                    PH_SET_LO:
                    begin
                        if (reached)
                        begin
                            phase_next = PH_W_NST_LO;
                            cnt_next   = 16'd0;
                        end
                        else
                            cnt_next = cnt_inc;
                    end
                    PH_W_NST_LO:
                    begin
                        if (!nstatus_level)
                        begin
                            cnt_next = 16'd0;
                            if (cfg.use_cd)
                                phase_next = PH_W_CD_LO;
                            else
                            begin
                                ncfg_next  = 1'b1;
                                phase_next = PH_W_NST_HI;
                            end
                        end
                        else if (reached)
                        begin
                            err_next   = ERR_NST_HIGH;
                            phase_next = PH_FAIL;
                            cnt_next   = 16'd0;
                        end
                        else
                            cnt_next = cnt_inc;
                    end
                    PH_W_CD_LO:
                    begin
                        if (!conf_done_level)
                        begin
                            ncfg_next  = 1'b1;
                            phase_next = PH_W_NST_HI;
                            cnt_next   = 16'd0;
                        end
                        else if (reached)
                        begin
                            err_next   = ERR_CD_HIGH;
                            phase_next = PH_FAIL;
                            cnt_next   = 16'd0;
                        end
                        else
                            cnt_next = cnt_inc;
                    end
                    PH_W_NST_HI:
                    begin
                        if (nstatus_level)
                        begin
                            phase_next = PH_LOAD;
                            cnt_next   = 16'd0;
                        end
                        else if (reached)
                        begin
                            err_next   = ERR_NST_LOW;
                            phase_next = PH_FAIL;
                            cnt_next   = 16'd0;
                        end
                        else
                            cnt_next = cnt_inc;
                    end
                    PH_W_DONE:
                    begin
                        if (conf_done_level)
                        begin
                            phase_next = PH_DONE;
                            cnt_next   = 16'd0;
                        end
                        else if (reached)
                        begin
                            err_next   = ERR_CD_NEVER;
                            phase_next = PH_FAIL;
                            cnt_next   = 16'd0;
                        end
                        else
                            cnt_next = cnt_inc;
                    end
                    PH_ABORT:
                    begin
                        if (reached)
                        begin
                            ncfg_next  = 1'b1;
                            phase_next = PH_IDLE;
                            cnt_next   = 16'd0;
                        end
                        else
                            cnt_next = cnt_inc;
                    end
                    default:
                    begin
                        // idle, load, done, fail: tick ignored
                    end
                endcase
            end
            OP_DATA:
            begin
                if (phase_reg == PH_LOAD)
                begin
                    pulse = 1'b1;
                    if (last_byte)
                    begin
                        phase_next = cfg.use_cd ? PH_W_DONE : PH_DONE;
                        cnt_next   = 16'd0;
                    end
                end
                else
                    err_next = ERR_BYTE_UNEXP;
            end
            default:
            begin
                ncfg_next  = 1'b0;
                phase_next = PH_ABORT;
                cnt_next   = 16'd0;
            end
        endcase
    end

    // Result carries the state after this item
    assign res = '{nconfig: ncfg_next, phase: phase_next, error: err_next,
                   pulse: pulse, data: data_byte};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= 16'd0;
            err_reg   <= ERR_NONE;
            ncfg_reg  <= 1'b1;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            err_reg   <= err_next;
            ncfg_reg  <= ncfg_next;
        end
    end

endmodule

>>> rtl/fpsl_ser.sv
// ----------------------------------------------------------------------------
// fpsl_ser
// Result register and bit serializer: one beat per item, eight for a pulsed byte.
// ----------------------------------------------------------------------------
module fpsl_ser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  fpsl_pkg::fpsl_res_t res_in,
    input  logic                out_ready,
    output logic                out_valid,
    output logic                nconfig_level,
    output logic                data_level,
    output logic                dclk_pulse,
    output logic [3:0]          phase,
    output logic [2:0]          error_code,
    output logic                last_of_run,
    output logic                free
);
    import fpsl_pkg::*;

    localparam int IDX_W = $clog2(BYTE_W);

    logic             valid_reg;
    logic [IDX_W-1:0] idx_reg;
    fpsl_res_t        res_reg;
    logic             last_beat;
    logic             advance;

    assign last_beat = !res_reg.pulse || (idx_reg == IDX_W'(BYTE_W - 1));
    assign advance   = valid_reg && out_ready;
    assign free      = !valid_reg || (out_ready && last_beat);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (advance)
        begin
            if (last_beat)
                valid_reg <= 1'b0;
            else
                idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    // Payload: no reset; data shifts right, LSB goes out first
    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_in;
        else if (advance && !last_beat)
            res_reg.data <= res_reg.data >> 1;
    end

    assign out_valid     = valid_reg;
    assign nconfig_level = res_reg.nconfig;
    assign data_level    = res_reg.pulse & res_reg.data[0];
    assign dclk_pulse    = res_reg.pulse;
    assign phase         = res_reg.phase;
    assign error_code    = res_reg.error;
    assign last_of_run   = last_beat;

endmodule

>>> rtl/fpga_passive_serial_loader.sv
// ----------------------------------------------------------------------------
// fpga_passive_serial_loader
// Passive serial configuration sequencer with APB register port.
// ----------------------------------------------------------------------------
// Timing: the first result beat is registered and valid in the cycle after the
//   command beat is taken. Start/tick/abort and rejected bytes give one beat;
//   a byte in the load phase gives eight beats through the single-bit output
//   serializer, and no new command is taken until its last beat is handed over.
// Reset: rst_n asynchronous, active low; phase idle, nCONFIG high, no error,
//   registers at their defaults, no result pending.
// ----------------------------------------------------------------------------
module fpga_passive_serial_loader (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // command and result channels
    fpsl_in_if.sink     in_ch,
    fpsl_out_if.source  out_ch
);
    import fpsl_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    fpsl_cfg_t  cfg_reg;
    logic       cfg_wr;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    // write lands on the access cycle
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.use_cd   <= USE_CD_RST;
            cfg_reg.settle   <= SETTLE_RST;
            cfg_reg.init_lim <= INIT_LIM_RST;
            cfg_reg.done_lim <= DONE_LIM_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_USE_CD:   cfg_reg.use_cd   <= pwdata[0];
                REG_SETTLE:   cfg_reg.settle   <= pwdata[15:0];
                REG_INIT_LIM: cfg_reg.init_lim <= pwdata[15:0];
                default:      cfg_reg.done_lim <= pwdata[15:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_USE_CD:   prdata = {31'd0, cfg_reg.use_cd};
            REG_SETTLE:   prdata = {16'd0, cfg_reg.settle};
            REG_INIT_LIM: prdata = {16'd0, cfg_reg.init_lim};
            default:      prdata = {16'd0, cfg_reg.done_lim};
        endcase
    end

    // ------------------------------------------------------------------
    // Command intake: a new beat is taken whenever the result register is
    // empty or is handing over its final beat this cycle.
    // ------------------------------------------------------------------
    logic      ser_free;
    logic      accept;
    fpsl_res_t res;

    assign in_ch.ready = ser_free;
    assign accept      = in_ch.valid && ser_free;

    // State machine; its next state is the result snapshot
    fpsl_seq u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .op              (in_ch.op),
        .data_byte       (in_ch.data_byte),
        .last_byte       (in_ch.last_byte),
        .nstatus_level   (in_ch.nstatus_level),
        .conf_done_level (in_ch.conf_done_level),
        .cfg             (cfg_reg),
        .res             (res)
    );

    // Result register; expands a loaded byte into eight DCLK beats
    fpsl_ser u_ser (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (accept),
        .res_in        (res),
        .out_ready     (out_ch.ready),
        .out_valid     (out_ch.valid),
        .nconfig_level (out_ch.nconfig_level),
        .data_level    (out_ch.data_level),
        .dclk_pulse    (out_ch.dclk_pulse),
        .phase         (out_ch.phase),
        .error_code    (out_ch.error_code),
        .last_of_run   (out_ch.last_of_run),
        .free          (ser_free)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> out_ch.valid)
        else $error("accepted command produced no result beat");

    a_no_intake_mid_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.last_of_run |-> !in_ch.ready)
        else $error("command taken while a byte is still shifting out");

    a_pulse_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.dclk_pulse |->
            (out_ch.phase == PH_LOAD) || (out_ch.phase == PH_W_DONE) ||
            (out_ch.phase == PH_DONE))
        else $error("DCLK pulse outside loading");

    a_nconfig_low: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && ((out_ch.phase == PH_SET_LO) || (out_ch.phase == PH_ABORT))
            |-> !out_ch.nconfig_level)
        else $error("nCONFIG not low in settle-low or abort");

    a_quiet_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.dclk_pulse |-> !out_ch.data_level && out_ch.last_of_run)
        else $error("data level or run marker wrong on pulseless beat");

endmodule

>>> tb/fpga_passive_serial_loader_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fpga_passive_serial_loader_tb
// Self-checking bench for the passive serial loader. Commands are driven on the
// input channel with random gaps, and result beats are taken with random
// stalls. A scoreboard mirrors the configuration sequencer and the bit shifter.
// It predicts the beats of every accepted command and compares each beat
// field by field, in order. Registers are written over the APB port only while
// no beat is outstanding.
// ----------------------------------------------------------------------------
module fpga_passive_serial_loader_tb;
    import fpsl_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 300;

    // One command as the loader sees it
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data_byte;
        logic       last_byte;
        logic       nstatus_level;
        logic       conf_done_level;
    } loader_cmd_t;

    // One result beat: pin levels, phase and error after the command
    typedef struct packed {
        logic       nconfig;
        logic       data;
        logic       dclk;
        logic [3:0] phase;
        logic [2:0] error;
        logic       last;
    } pin_beat_t;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the registers and of the sequencer state, and
    // the beats still due from the block, oldest first.
    // ------------------------------------------------------------------------
    class pin_scoreboard;
        bit          use_cd;
        logic [15:0] settle_lim;
        logic [15:0] init_lim;
        logic [15:0] done_lim;
        logic [3:0]  phase;
        logic [15:0] wait_cnt;
        logic [2:0]  err;
        logic        ncfg;
        pin_beat_t   pin_beats_due[$];
        int          beats_checked;
        int          mismatches;

        function new();
            use_cd        = USE_CD_RST;
            settle_lim    = SETTLE_RST;
            init_lim      = INIT_LIM_RST;
            done_lim      = DONE_LIM_RST;
            phase         = PH_IDLE;
            wait_cnt      = '0;
            err           = ERR_NONE;
            ncfg          = 1'b1;
            beats_checked = 0;
            mismatches    = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [15:0] value);
            case (idx)
                REG_USE_CD:   use_cd = value[0];
                REG_SETTLE:   settle_lim = value;
                REG_INIT_LIM: init_lim = value;
                REG_DONE_LIM: done_lim = value;
                default: ;
            endcase
        endfunction

        // One counted tick; a zero limit trips on the first count, and so
        // does a counter that wraps.
        function bit count_hits(logic [15:0] lim);
            wait_cnt = wait_cnt + 16'd1;
            return (wait_cnt >= lim) || (wait_cnt == 16'd0);
        endfunction

        function void enter(logic [3:0] next_phase);
            phase    = next_phase;
            wait_cnt = '0;
        endfunction

        function void trip(logic [2:0] code);
            err = code;
            enter(PH_FAIL);
        endfunction

        // Waits test the awaited level first and count only on a miss
        function void sequence_tick(logic nst, logic cd);
            case (phase)
                PH_SET_HI:
                    if (count_hits(settle_lim))
                    begin
                        ncfg = 1'b0;
                        enter(PH_SET_LO);
                    end
                PH_SET_LO:
                    if (count_hits(settle_lim))
                        enter(PH_W_NST_LO);
                PH_W_NST_LO:
                    if (!nst)
                    begin
                        if (use_cd)
                            enter(PH_W_CD_LO);
                        else
                        begin
                            ncfg = 1'b1;
                            enter(PH_W_NST_HI);
                        end
                    end
                    else if (count_hits(init_lim))
                        trip(ERR_NST_HIGH);
                PH_W_CD_LO:
                    if (!cd)
                    begin
                        ncfg = 1'b1;
                        enter(PH_W_NST_HI);
                    end
                    else if (count_hits(init_lim))
                        trip(ERR_CD_HIGH);
                PH_W_NST_HI:
                    if (nst)
                        enter(PH_LOAD);
                    else if (count_hits(init_lim))
                        trip(ERR_NST_LOW);
                PH_W_DONE:
                    if (cd)
                        enter(PH_DONE);
                    else if (count_hits(done_lim))
                        trip(ERR_CD_NEVER);
                PH_ABORT:
                    if (count_hits(settle_lim))
                    begin
                        ncfg = 1'b1;
                        enter(PH_IDLE);
                    end
                default: ;
            endcase
        endfunction

        function void push_beat(logic data, logic dclk, logic last);
            pin_beat_t b;
            b.nconfig = ncfg;
            b.data    = data;
            b.dclk    = dclk;
            b.phase   = phase;
            b.error   = err;
            b.last    = last;
            pin_beats_due.push_back(b);
        endfunction

        // Called once per accepted command beat
        function void note_command(loader_cmd_t c);
            case (c.op)
                OP_START:
                begin
                    ncfg = 1'b1;
                    err  = ERR_NONE;
                    enter(PH_SET_HI);
                end
                OP_TICK:
                    sequence_tick(c.nstatus_level, c.conf_done_level);
                OP_DATA:
                begin
                    if (phase == PH_LOAD)
                    begin
                        // phase moves on before the bits go out
                        if (c.last_byte)
                            enter(use_cd ? PH_W_DONE : PH_DONE);
                        for (int j = 0; j < 8; j++)
                            push_beat(c.data_byte[j], 1'b1, j == 7);
                        return;
                    end
                    err = ERR_BYTE_UNEXP;
                end
                default:
                begin
                    ncfg = 1'b0;
                    enter(PH_ABORT);
                end
            endcase
            push_beat(1'b0, 1'b0, 1'b1);
        endfunction

        task report(string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_pins(pin_beat_t got);
            pin_beat_t want;
            string     diff;
            beats_checked++;
            if (pin_beats_due.size() == 0)
            begin
                report($sformatf("beat %0d arrived with nothing due (ph %0d err %0d)",
                                 beats_checked, got.phase, got.error));
                return;
            end
            want = pin_beats_due.pop_front();
            diff = "";
            if (got.nconfig !== want.nconfig) diff = {diff, " nconfig"};
            if (got.data    !== want.data)    diff = {diff, " data"};
            if (got.dclk    !== want.dclk)    diff = {diff, " dclk"};
            if (got.phase   !== want.phase)   diff = {diff, " phase"};
            if (got.error   !== want.error)   diff = {diff, " error"};
            if (got.last    !== want.last)    diff = {diff, " last"};
            if (diff != "")
                report($sformatf({"beat %0d bad%s: got ncfg%b d%b clk%b ph%0d err%0d last%b,",
                                  " want ncfg%b d%b clk%b ph%0d err%0d last%b"},
                                 beats_checked, diff,
                                 got.nconfig, got.data, got.dclk, got.phase, got.error,
                                 got.last, want.nconfig, want.data, want.dclk, want.phase,
                                 want.error, want.last));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    fpsl_in_if  cmd_ch ();
    fpsl_out_if res_ch ();

    pin_scoreboard sb = new();

    bit tx_calm      = 1'b0;   // sender runs back to back while set
    bit hold_off_req = 1'b0;   // asks the receiver for one long hold-off
    int work_items   = 0;      // accepted commands that do more than nothing

    always #5 clk = ~clk;

    fpga_passive_serial_loader uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (cmd_ch),
        .out_ch  (res_ch)
    );

    // ------------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------------

    // Mostly short gaps, now and then a long one
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_calm || r < 70)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Offers one command and holds it until the beat is taken. With no gap,
    // valid stays high and the caller puts the next command on the bus in
    // the same step.
    task automatic send(logic [1:0] op, logic [7:0] data, logic last, logic nst,
                        logic cd);
        loader_cmd_t c;
        int          gap;
        c = '{op, data, last, nst, cd};
        cmd_ch.valid           <= 1'b1;
        cmd_ch.op              <= op;
        cmd_ch.data_byte       <= data;
        cmd_ch.last_byte       <= last;
        cmd_ch.nstatus_level   <= nst;
        cmd_ch.conf_done_level <= cd;
        do
            @(posedge clk);
        while (!(cmd_ch.valid && cmd_ch.ready));
        // ticks outside the timed phases change nothing
        if (!(op == OP_TICK && sb.phase inside {PH_IDLE, PH_LOAD, PH_DONE, PH_FAIL}))
            work_items++;
        sb.note_command(c);
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Tick with pin levels chosen for the current phase: the awaited level
    // shows up with hit_pct percent odds, never in the phase held as stuck.
    // PH_IDLE as stuck_at means no phase is held.
    task automatic pin_tick(logic [3:0] stuck_at, int hit_pct);
        bit   hit;
        logic nst;
        logic cd;
        hit = (sb.phase != stuck_at) && ($urandom_range(0, 99) < hit_pct);
        nst = rand_bit();
        cd  = rand_bit();
        case (sb.phase)
            PH_W_NST_LO: nst = !hit;
            PH_W_CD_LO:  cd  = !hit;
            PH_W_NST_HI: nst = hit;
            PH_W_DONE:   cd  = hit;
            default: ;
        endcase
        send(OP_TICK, rand_byte(), rand_bit(), nst, cd);
    endtask

    // Ticks until the sequencer leaves its timed phases
    task automatic wait_levels(logic [3:0] stuck_at, int hit_pct);
        while (sb.phase inside {PH_SET_HI, PH_SET_LO, PH_W_NST_LO, PH_W_CD_LO,
                                PH_W_NST_HI, PH_W_DONE, PH_ABORT})
            pin_tick(stuck_at, hit_pct);
    endtask

    // Whole configuration run: start, init handshake, image, done wait
    task automatic run_image(int n_bytes, logic [3:0] stuck_at, int hit_pct);
        send(OP_START, rand_byte(), rand_bit(), rand_bit(), rand_bit());
        wait_levels(stuck_at, hit_pct);
        for (int i = 0; i < n_bytes && sb.phase == PH_LOAD; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                pin_tick(stuck_at, hit_pct);
            send(OP_DATA, rand_byte(), i == n_bytes - 1, rand_bit(), rand_bit());
        end
        wait_levels(stuck_at, hit_pct);
    endtask

    // Start cut short: abort, a stray byte, or a restart into a full run
    task automatic broken_run();
        send(OP_START, rand_byte(), rand_bit(), rand_bit(), rand_bit());
        repeat ($urandom_range(0, 5))
            if (sb.phase inside {PH_SET_HI, PH_SET_LO, PH_W_NST_LO, PH_W_CD_LO, PH_W_NST_HI})
                pin_tick(PH_IDLE, 60);
        case ($urandom_range(0, 2))
            0:
            begin
                send(OP_ABORT, rand_byte(), rand_bit(), rand_bit(), rand_bit());
                wait_levels(PH_IDLE, 60);
            end
            1:
            begin
                send(OP_DATA, rand_byte(), rand_bit(), rand_bit(), rand_bit());
                wait_levels(PH_IDLE, 60);
            end
            default:
                run_image($urandom_range(1, 3), PH_IDLE, 60);
        endcase
    endtask

    // Waits until every predicted beat has been seen
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        while (sb.pin_beats_due.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // APB side: setup then access; psel is dropped by configure() after the
    // last write so no signal gets two updates in one step.
    // ------------------------------------------------------------------------
    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0000, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_register(idx, value);
    endtask

    task automatic configure(bit ucd, logic [15:0] settle, logic [15:0] init_w,
                             logic [15:0] done_w);
        drain();
        write_reg(REG_USE_CD, {15'd0, ucd});
        write_reg(REG_SETTLE, settle);
        write_reg(REG_INIT_LIM, init_w);
        write_reg(REG_DONE_LIM, done_w);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls, calm stretches, and one long hold-off on
    // request so the block backs up and stops taking commands.
    // ------------------------------------------------------------------------
    initial
    begin
        int        stall_left;
        bit        rx_calm;
        pin_beat_t got;
        stall_left   = 0;
        rx_calm      = 1'b0;
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
            begin
                got = {res_ch.nconfig_level, res_ch.data_level, res_ch.dclk_pulse,
                       res_ch.phase, res_ch.error_code, res_ch.last_of_run};
                sb.check_pins(got);
                if (sb.beats_checked % 97 == 0)
                    rx_calm = ($urandom_range(0, 3) == 0);
            end
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall_left   = 300;
            end
            else if (stall_left == 0 && !rx_calm && $urandom_range(0, 99) < 20)
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(1, 3);
            if (stall_left > 0)
            begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // Watchdog
    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d beats still due", cycles,
                 sb.pin_beats_due.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int         image_idx;
        int         pick;
        logic [3:0] stuck;
        bit         small_lims;

        rst_n                  = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        cmd_ch.valid           = 1'b0;
        cmd_ch.op              = OP_TICK;
        cmd_ch.data_byte       = '0;
        cmd_ch.last_byte       = 1'b0;
        cmd_ch.nstatus_level   = 1'b0;
        cmd_ch.conf_done_level = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults, long settle: stray inputs, restart, abort
        send(OP_TICK,  8'h00, 1'b0, 1'b0, 1'b0);  // tick in idle
        send(OP_DATA,  8'hFF, 1'b1, 1'b1, 1'b1);  // byte in idle flags error
        send(OP_START, 8'h00, 1'b0, 1'b1, 1'b1);  // start clears the error
        send(OP_TICK,  8'hFF, 1'b1, 1'b1, 1'b1);  // settle counts, still high
        send(OP_DATA,  8'h5A, 1'b0, 1'b0, 1'b0);  // byte during settle
        send(OP_START, 8'hA5, 1'b1, 1'b0, 1'b1);  // restart mid-settle
        send(OP_ABORT, 8'hFF, 1'b1, 1'b1, 1'b0);
        send(OP_TICK,  8'h00, 1'b0, 1'b0, 1'b1);  // abort hold counts

        // Short settle, small limits: walk every phase but fail, one miss at each wait
        configure(1'b1, 16'd1, 16'd3, 16'd2);
        send(OP_START, 8'h00, 1'b0, 1'b0, 1'b0);
        send(OP_TICK,  8'h00, 1'b0, 1'b1, 1'b1);  // to settle low
        send(OP_TICK,  8'h00, 1'b0, 1'b1, 1'b1);  // to nSTATUS low wait
        send(OP_TICK,  8'h00, 1'b0, 1'b1, 1'b0);  // miss
        send(OP_TICK,  8'h00, 1'b0, 1'b0, 1'b1);  // nSTATUS low seen
        send(OP_TICK,  8'h00, 1'b0, 1'b0, 1'b1);  // miss
        send(OP_TICK,  8'h00, 1'b0, 1'b1, 1'b0);  // CONF_DONE low, release
        send(OP_TICK,  8'h00, 1'b0, 1'b0, 1'b1);  // miss
        send(OP_TICK,  8'h00, 1'b0, 1'b1, 1'b0);  // nSTATUS high, load
        send(OP_TICK,  8'hFF, 1'b1, 1'b0, 1'b0);  // tick while loading
        send(OP_DATA,  8'h00, 1'b0, 1'b0, 1'b0);
        send(OP_DATA,  8'hFF, 1'b0, 1'b1, 1'b1);
        send(OP_DATA,  8'hA5, 1'b1, 1'b0, 1'b0);  // last byte
        send(OP_TICK,  8'h00, 1'b0, 1'b1, 1'b0);  // miss
        send(OP_TICK,  8'h00, 1'b0, 1'b0, 1'b1);  // done
        send(OP_TICK,  8'h00, 1'b0, 1'b0, 1'b0);  // tick when done
        send(OP_DATA,  8'h3C, 1'b1, 1'b1, 1'b1);  // byte when done
        send(OP_ABORT, 8'h00, 1'b0, 1'b0, 1'b0);
        send(OP_TICK,  8'h00, 1'b0, 1'b0, 1'b0);  // back to idle

        // A timeout at each wait, then a tick while failed
        run_image(1, PH_W_NST_LO, 70);
        pin_tick(PH_IDLE, 50);
        run_image(1, PH_W_CD_LO, 70);
        run_image(1, PH_W_NST_HI, 70);
        run_image(2, PH_W_DONE, 70);

        // CONF_DONE ignored
        configure(1'b0, 16'd2, 16'd1, 16'd1);
        run_image(2, PH_IDLE, 70);
        run_image(3, PH_IDLE, 70);

        // Zero limits trip on the first miss
        configure(1'b1, 16'd1, 16'd0, 16'd0);
        run_image(2, PH_IDLE, 50);
        run_image(2, PH_IDLE, 50);

        // Widest limits with a short settle
        configure(1'b1, 16'd1, 16'hFFFF, 16'hFFFF);
        run_image(2, PH_IDLE, 40);
        run_image(1, PH_IDLE, 40);

        // Widest settle: only a few ticks, abort, restart
        configure(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send(OP_START, 8'h00, 1'b0, 1'b0, 1'b0);
        repeat (3) pin_tick(PH_IDLE, 50);
        send(OP_ABORT, 8'hFF, 1'b1, 1'b1, 1'b1);
        repeat (2) pin_tick(PH_IDLE, 50);
        send(OP_START, 8'h00, 1'b0, 1'b0, 1'b0);
        pin_tick(PH_IDLE, 50);

        // Long receiver hold-off while a long image is pushed back to back
        configure(1'b1, 16'd2, 16'd4, 16'd4);
        hold_off_req = 1'b1;
        tx_calm      = 1'b1;
        run_image(12, PH_IDLE, 100);
        tx_calm      = 1'b0;

        // Random part: mostly clean runs with random content, some timeouts,
        // cut-short runs and noise; new settings every few runs
        work_items = 0;
        image_idx  = 0;
        while (work_items < RANDOM_ITEMS)
        begin
            if (image_idx % 5 == 0)
            begin
                if ($urandom_range(0, 9) == 0)
                    configure(rand_bit(), 16'd1, 16'hFFFF, 16'hFFFF);
                else
                    configure(rand_bit(),
                              ($urandom_range(0, 9) == 0) ? 16'($urandom_range(5, 20))
                                                          : 16'($urandom_range(1, 4)),
                              16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)));
            end
            image_idx++;
            small_lims = (sb.init_lim <= 16'd100) && (sb.done_lim <= 16'd100);
            tx_calm    = ($urandom_range(0, 3) == 0);
            pick       = $urandom_range(0, 99);
            if (pick < 68)
                run_image($urandom_range(1, 5), PH_IDLE, $urandom_range(30, 90));
            else if (pick < 80)
            begin
                // a forced timeout needs a short limit to end soon
                case ($urandom_range(0, 3))
                    0:       stuck = PH_W_NST_LO;
                    1:       stuck = PH_W_CD_LO;
                    2:       stuck = PH_W_NST_HI;
                    default: stuck = PH_W_DONE;
                endcase
                run_image($urandom_range(1, 3), small_lims ? stuck : PH_IDLE, 60);
            end
            else if (pick < 92)
                broken_run();
            else
                repeat ($urandom_range(1, 6))
                    send(2'($urandom_range(0, 3)), rand_byte(), rand_bit(), rand_bit(),
                         rand_bit());

            // stray input after the run
            pick = $urandom_range(0, 99);
            if (pick < 20)
                pin_tick(PH_IDLE, 50);
            else if (pick < 35)
                send(OP_DATA, rand_byte(), rand_bit(), rand_bit(), rand_bit());
            else if (pick < 50)
            begin
                send(OP_ABORT, rand_byte(), rand_bit(), rand_bit(), rand_bit());
                wait_levels(PH_IDLE, 50);
            end
        end
        tx_calm = 1'b0;

        // Let the last beats out, then a short quiet stretch for strays
        drain();
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
